// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the force curve feature extractor RTL.
// No dependencies; files with concurrent checks take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define FCFE_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fcfe assertion failed");
// Check that a trigger is followed by a condition in the next cycle.
`define FCFE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("fcfe assertion failed");
`else
`define FCFE_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define FCFE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)
`endif
`endif

// ----- rtl/core/fcfe_pkg.sv -----
// Shared constants for the force curve feature extractor.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package fcfe_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER    = 2'd2;

    // Work integrals wrap modulo 2^64; the result drops the halved top bit
    localparam int WORK_W  = 64;
    localparam int DWORK_W = WORK_W - 1;

    // Fit window is usable when end minus start exceeds this
    localparam int FIT_MIN_GAP = 4;

endpackage

`default_nettype wire

// ----- rtl/core/fcfe_ifs.sv -----
// Valid/ready channel interfaces of the force curve feature extractor:
// sample input, result output and configuration write. Depends on fcfe_pkg.
`default_nettype none

interface fcfe_smp_if #(
    parameter int SW = 24
) ();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic signed [SW-1:0] position;
    logic signed [SW-1:0] force_req;
    logic                 last;

    modport source (output valid, req_type, position, force_req, last, input ready);
    modport sink   (input valid, req_type, position, force_req, last, output ready);
endinterface

interface fcfe_res_if import fcfe_pkg::*; #(
    parameter int SW = 24,
    parameter int IW = 12
) ();
    logic                      valid;
    logic                      ready;
    logic signed [SW:0]        adhesion_force;
    logic signed [SW-1:0]      adhesion_x;
    logic signed [SW-1:0]      baseline_force;
    logic signed [SW-1:0]      peak_force;
    logic signed [SW-1:0]      peak_x;
    logic signed [SW-1:0]      zero_x;
    logic signed [SW:0]        deformation;
    logic signed [DWORK_W-1:0] dissipated_work;
    logic [IW-1:0]             fit_start_index;
    logic [IW-1:0]             fit_end_index;
    logic                      fit_window_ok;
    logic                      baseline_empty;

    modport source (output valid, adhesion_force, adhesion_x, baseline_force, peak_force,
                    peak_x, zero_x, deformation, dissipated_work, fit_start_index,
                    fit_end_index, fit_window_ok, baseline_empty, input ready);
    modport sink   (input valid, adhesion_force, adhesion_x, baseline_force, peak_force,
                    peak_x, zero_x, deformation, dissipated_work, fit_start_index,
                    fit_end_index, fit_window_ok, baseline_empty, output ready);
endinterface

interface fcfe_cfg_if import fcfe_pkg::*; #(
    parameter int DW = 17
) ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [DW-1:0]        data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fcfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fcfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/force_curve_feature_extractor.sv -----
// Force curve feature extractor: top level. Depends on fcfe_pkg, the channel
// interfaces in fcfe_ifs.sv, fcfe_ram and assert_macros.svh.
//
// Accepts an approach curve and then a retract curve as signed (position,
// force) words and returns one result word after the retract word marked
// last: baseline force, adhesion, peak, zero-crossing position, deformation,
// dissipated work and a fit window on the retract curve. Each sample word
// goes through accept and store, multiply and accumulate, using the one
// shared multiplier. The last retract word then starts the analysis: one
// pass over the approach memory for the baseline, a bit-serial divide for
// its mean unless the baseline is empty, a second approach pass for the
// zero crossing and one retract pass for the fit window, each pass reading
// one sample a cycle from the single read port of its curve memory. The
// sample port is not ready during all of this. A finished result waits in
// an output register; the next curve pair may load meanwhile. Samples
// beyond MAX_SAMPLES per curve are dropped. Configuration writes are always
// taken and must only happen while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module force_curve_feature_extractor import fcfe_pkg::*; #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcfe_smp_if.sink   i_smp,
    fcfe_res_if.source o_res,
    fcfe_cfg_if.sink   i_cfg
);

    localparam int SW   = SAMPLE_BITS;
    localparam int FB   = FRAC_BITS;
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CNW  = $clog2(MAX_SAMPLES + 1);
    localparam int MW   = (SW > FB) ? SW + 2 : FB + 2;   // multiplier operand
    localparam int PW   = 2 * MW;                        // product
    localparam int CW   = PW + 1;                        // baseline compare
    localparam int BSW  = SW + CNW;                      // baseline sum
    localparam int DCW  = $clog2(BSW + 1);

    localparam logic [CNW-1:0] MAXN     = CNW'(MAX_SAMPLES);
    localparam logic [CNW-1:0] SCAN_LO  = CNW'(2);
    localparam logic [CNW-1:0] PAIR_LO  = CNW'(3);
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};

    // Register defaults: 0.2, 0.8 and 0.2 of full scale, rounded
    localparam logic [FB-1:0] FRAC_B_RST = FB'((2**FB + 2) / 5);
    localparam logic [FB:0]   FRAC_U_RST = (FB+1)'((4 * 2**FB + 2) / 5);
    localparam logic [FB-2:0] FRAC_L_RST = (FB-1)'((2**FB + 2) / 5);

    // Sequencer
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_BMUL  = 4'd3;
    localparam logic [3:0] S_BSCAN = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_DIVF  = 4'd6;
    localparam logic [3:0] S_ZSCAN = 4'd7;
    localparam logic [3:0] S_UMUL  = 4'd8;
    localparam logic [3:0] S_LMUL  = 4'd9;
    localparam logic [3:0] S_FTHR  = 4'd10;
    localparam logic [3:0] S_FSCAN = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] r_state;

    // Configuration
    logic [FB-1:0] r_frac_b;
    logic [FB:0]   r_frac_u;
    logic [FB-2:0] r_frac_l;

    // Running curve state
    logic [CNW-1:0]       r_cnt_app, r_cnt_ret;
    logic signed [SW-1:0] r_apk_f, r_apk_x, r_rpk_f, r_rpk_x;
    logic signed [SW-1:0] r_adh_f, r_adh_x;
    logic [AW-1:0]        r_adh_i;
    logic signed [SW-1:0] r_xmax, r_xmin;
    logic signed [SW-1:0] r_pa_x, r_pa_f, r_pr_x, r_pr_f;
    logic [WORK_W-1:0]    r_work_a, r_work_r;

    // Trapezoid step
    logic [SW:0]          r_dx_abs;
    logic signed [SW:0]   r_fsum;
    logic                 r_acc_en, r_acc_ret, r_fin;
    logic signed [PW-1:0] r_prod;

    // Memory scans
    logic [CNW-1:0] r_ptr, r_lim, r_dv_idx;
    logic           r_dv;

    // Baseline and divider
    logic signed [BSW-1:0] r_bsum;
    logic [CNW-1:0]        r_bcnt;
    logic [BSW-1:0]        r_quo;
    logic [CNW-1:0]        r_rem;
    logic [DCW-1:0]        r_dcnt;
    logic                  r_dneg;
    logic signed [SW-1:0]  r_base;
    logic signed [SW:0]    r_thr;

    // Zero crossing
    logic signed [SW-1:0] r_zx, r_hold_f, r_hold_x;
    logic                 r_zfound;

    // Fit window
    logic signed [PW-1:0] r_tu, r_tl, r_dprev;
    logic [AW-1:0]        r_iup, r_ilo;
    logic                 r_ufound, r_lfound;
    logic [WORK_W-1:0]    r_wdiff;

    // Result register
    logic                      r_out_valid;
    logic signed [SW:0]        r_o_adh_f;
    logic signed [SW-1:0]      r_o_adh_x, r_o_base, r_o_pk_f, r_o_pk_x, r_o_zx;
    logic signed [SW:0]        r_o_deform;
    logic [DWORK_W-1:0]        r_o_work;
    logic [AW-1:0]             r_o_istart, r_o_iend;
    logic                      r_o_win_ok, r_o_bempty;

    // ------------------------------------------------------------------
    // Sample intake
    // ------------------------------------------------------------------
    logic                 w_smp_acc, w_kind, w_room, w_store;
    logic [CNW-1:0]       w_n;
    logic signed [SW-1:0] w_x, w_f, w_px, w_pf;
    logic signed [SW:0]   w_dx, w_fsum;

    assign i_smp.ready = (r_state == S_IDLE);
    assign w_smp_acc   = i_smp.valid && i_smp.ready;
    assign w_kind      = i_smp.req_type;
    assign w_x         = i_smp.position;
    assign w_f         = i_smp.force_req;
    assign w_n         = w_kind ? r_cnt_ret : r_cnt_app;
    assign w_room      = (w_n < MAXN);
    assign w_store     = w_smp_acc && w_room;
    assign w_px        = w_kind ? r_pr_x : r_pa_x;
    assign w_pf        = w_kind ? r_pr_f : r_pa_f;
    assign w_dx        = {w_x[SW-1], w_x} - {w_px[SW-1], w_px};
    assign w_fsum      = {w_f[SW-1], w_f} + {w_pf[SW-1], w_pf};

    // ------------------------------------------------------------------
    // Curve memories: approach keeps {position, force}, retract keeps force
    // ------------------------------------------------------------------
    logic [2*SW-1:0]      w_app_q;
    logic [SW-1:0]        w_ret_q;
    logic signed [SW-1:0] w_qa_x, w_qa_f, w_qr_f;

    fcfe_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_SAMPLES)
    ) u_app_ram (
        .i_clk   (i_clk),
        .i_we    (w_store && !w_kind),
        .i_waddr (w_n[AW-1:0]),
        .i_wdata ({w_x, w_f}),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_app_q)
    );

    fcfe_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SAMPLES)
    ) u_ret_ram (
        .i_clk   (i_clk),
        .i_we    (w_store && w_kind),
        .i_waddr (w_n[AW-1:0]),
        .i_wdata (w_f),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_ret_q)
    );

    assign w_qa_x = w_app_q[2*SW-1:SW];
    assign w_qa_f = w_app_q[SW-1:0];
    assign w_qr_f = w_ret_q;

    // ------------------------------------------------------------------
    // Shared multiplier: trapezoid area, baseline cut, fit thresholds
    // ------------------------------------------------------------------
    logic signed [SW:0]   w_range, w_span;
    logic signed [SW-1:0] w_peak_f, w_peak_x;
    logic                 w_pk_app;
    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_prod;

    // Approach peak wins ties
    assign w_pk_app = (r_cnt_app != '0) && !(r_rpk_f > r_apk_f);
    assign w_peak_f = w_pk_app ? r_apk_f : r_rpk_f;
    assign w_peak_x = w_pk_app ? r_apk_x : r_rpk_x;
    assign w_range  = (r_cnt_app != '0) ?
                      ({r_xmax[SW-1], r_xmax} - {r_xmin[SW-1], r_xmin}) : '0;
    assign w_span   = {w_peak_f[SW-1], w_peak_f} - {r_adh_f[SW-1], r_adh_f};

    always_comb begin
        case (r_state)
            S_MUL: begin
                w_ma = $signed({{(MW-SW-1){1'b0}}, r_dx_abs});
                w_mb = $signed({{(MW-SW-1){r_fsum[SW]}}, r_fsum});
            end
            S_BMUL: begin
                w_ma = $signed({{(MW-FB){1'b0}}, r_frac_b});
                w_mb = $signed({{(MW-SW-1){w_range[SW]}}, w_range});
            end
            S_UMUL: begin
                w_ma = $signed({{(MW-FB-1){1'b0}}, r_frac_u});
                w_mb = $signed({{(MW-SW-1){w_span[SW]}}, w_span});
            end
            S_LMUL: begin
                w_ma = $signed({{(MW-FB+1){1'b0}}, r_frac_l});
                w_mb = $signed({{(MW-SW-1){w_span[SW]}}, w_span});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // ------------------------------------------------------------------
    // Scan datapath
    // ------------------------------------------------------------------
    logic                 w_issue, w_scan_done;
    logic signed [SW:0]   w_dxm, w_fdiff;
    logic signed [CW-1:0] w_blhs;
    logic                 w_bcond;
    logic signed [PW-1:0] w_dcur;
    logic signed [SW:0]   w_qa_fe, w_hold_fe;

    assign w_issue     = (r_ptr < r_lim);
    assign w_scan_done = !w_issue && !r_dv;

    // Baseline membership: (x - xmax) * 2^FB + frac * range > 0
    assign w_dxm   = {w_qa_x[SW-1], w_qa_x} - {r_xmax[SW-1], r_xmax};
    assign w_blhs  = (CW'(w_dxm) <<< FB) + CW'(r_prod);
    assign w_bcond = !w_blhs[CW-1] && (w_blhs != '0);

    assign w_qa_fe   = {w_qa_f[SW-1], w_qa_f};
    assign w_hold_fe = {r_hold_f[SW-1], r_hold_f};

    // Retract force above adhesion, in threshold scale
    assign w_fdiff = {w_qr_f[SW-1], w_qr_f} - {r_adh_f[SW-1], r_adh_f};
    assign w_dcur  = PW'(w_fdiff) <<< FB;

    // ------------------------------------------------------------------
    // Divider step and mean rounding
    // ------------------------------------------------------------------
    logic [CNW:0]          w_dtmp;
    logic                  w_dge;
    logic [CNW:0]          w_dsub;
    logic [BSW-1:0]        w_bmag;
    logic signed [BSW-1:0] w_q;
    logic                  w_inc;

    assign w_dtmp = {r_rem, r_quo[BSW-1]};
    assign w_dge  = (w_dtmp >= {1'b0, r_bcnt});
    assign w_dsub = w_dtmp - {1'b0, r_bcnt};
    assign w_bmag = r_bsum[BSW-1] ? (~r_bsum + 1'b1) : r_bsum;
    assign w_q    = r_dneg ? (~r_quo + 1'b1) : r_quo;
    // Ceiling of the mean: round a positive inexact quotient up
    assign w_inc  = (r_rem != '0) && !r_dneg;

    // ------------------------------------------------------------------
    // Result fields
    // ------------------------------------------------------------------
    logic [WORK_W-1:0]    w_wd;
    logic signed [AW+1:0] w_gap;

    // Halve toward zero: bias negatives by one before the shift
    assign w_wd  = r_wdiff + {{(WORK_W-1){1'b0}}, r_wdiff[WORK_W-1]};
    assign w_gap = $signed({2'b00, r_ilo}) - $signed({2'b00, r_iup});

    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Sequencer and registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_frac_b    <= FRAC_B_RST;
            r_frac_u    <= FRAC_U_RST;
            r_frac_l    <= FRAC_L_RST;
            r_cnt_app   <= '0;
            r_cnt_ret   <= '0;
            r_apk_f     <= SMIN;
            r_apk_x     <= '0;
            r_rpk_f     <= SMIN;
            r_rpk_x     <= '0;
            r_adh_f     <= SMAX;
            r_adh_x     <= '0;
            r_adh_i     <= '0;
            r_xmax      <= SMIN;
            r_xmin      <= SMAX;
            r_pa_x      <= '0;
            r_pa_f      <= '0;
            r_pr_x      <= '0;
            r_pr_f      <= '0;
            r_work_a    <= '0;
            r_work_r    <= '0;
        end else begin
            // Register writes must only be issued while idle; the block does not enforce this
            if (i_cfg.valid) begin
                case (i_cfg.addr)
                    CFG_BASELINE: r_frac_b <= i_cfg.data[FB-1:0];
                    CFG_UPPER:    r_frac_u <= i_cfg.data[FB:0];
                    CFG_LOWER:    r_frac_l <= i_cfg.data[FB-2:0];
                    default: ;
                endcase
            end

            // Drop the result once the sink takes it
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_smp_acc) begin
                        r_dx_abs  <= w_dx[SW] ? (~w_dx + 1'b1) : w_dx;
                        r_fsum    <= w_fsum;
                        r_acc_en  <= w_store && (w_n != '0);
                        r_acc_ret <= w_kind;
                        r_fin     <= w_kind && i_smp.last;
                        r_state   <= S_MUL;
                        if (w_store && !w_kind) begin
                            if ((w_n == '0) || (w_f > r_apk_f)) begin
                                r_apk_f <= w_f;
                                r_apk_x <= w_x;
                            end
                            if (w_x > r_xmax) begin
                                r_xmax <= w_x;
                            end
                            if (w_x < r_xmin) begin
                                r_xmin <= w_x;
                            end
                            r_pa_x    <= w_x;
                            r_pa_f    <= w_f;
                            r_cnt_app <= r_cnt_app + 1'b1;
                        end
                        if (w_store && w_kind) begin
                            // First minimum keeps its place
                            if ((w_n == '0) || (w_f < r_adh_f)) begin
                                r_adh_f <= w_f;
                                r_adh_x <= w_x;
                                r_adh_i <= w_n[AW-1:0];
                            end
                            if ((w_n == '0) || (w_f > r_rpk_f)) begin
                                r_rpk_f <= w_f;
                                r_rpk_x <= w_x;
                            end
                            r_pr_x    <= w_x;
                            r_pr_f    <= w_f;
                            r_cnt_ret <= r_cnt_ret + 1'b1;
                        end
                    end
                end

                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ACC;
                end

                S_ACC: begin
                    if (r_acc_en && !r_acc_ret) begin
                        r_work_a <= r_work_a + WORK_W'(r_prod);
                    end
                    if (r_acc_en && r_acc_ret) begin
                        r_work_r <= r_work_r + WORK_W'(r_prod);
                    end
                    r_state <= r_fin ? S_BMUL : S_IDLE;
                end

                S_BMUL: begin
                    r_prod  <= w_prod;
                    r_ptr   <= '0;
                    r_lim   <= r_cnt_app;
                    r_dv    <= 1'b0;
                    r_bsum  <= '0;
                    r_bcnt  <= '0;
                    r_state <= S_BSCAN;
                end

                S_BSCAN: begin
                    r_dv     <= w_issue;
                    r_dv_idx <= r_ptr;
                    if (w_issue) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (r_dv && w_bcond) begin
                        r_bsum <= r_bsum + BSW'(w_qa_f);
                        r_bcnt <= r_bcnt + 1'b1;
                    end
                    if (w_scan_done) begin
                        if (r_bcnt == '0) begin
                            // Empty baseline: mean and threshold are zero
                            r_base   <= '0;
                            r_thr    <= '0;
                            r_ptr    <= SCAN_LO;
                            r_lim    <= r_cnt_app;
                            r_dv     <= 1'b0;
                            r_zx     <= r_pa_x;
                            r_zfound <= 1'b0;
                            r_state  <= S_ZSCAN;
                        end else begin
                            r_dneg  <= r_bsum[BSW-1];
                            r_quo   <= w_bmag;
                            r_rem   <= '0;
                            r_dcnt  <= DCW'(BSW);
                            r_state <= S_DIV;
                        end
                    end
                end

                S_DIV: begin
                    r_rem  <= w_dge ? w_dsub[CNW-1:0] : w_dtmp[CNW-1:0];
                    r_quo  <= {r_quo[BSW-2:0], w_dge};
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= S_DIVF;
                    end
                end

                S_DIVF: begin
                    r_base   <= w_q[SW-1:0];
                    r_thr    <= w_q[SW:0] + {{SW{1'b0}}, w_inc};
                    r_ptr    <= SCAN_LO;
                    r_lim    <= r_cnt_app;
                    r_dv     <= 1'b0;
                    r_zx     <= r_pa_x;
                    r_zfound <= 1'b0;
                    r_state  <= S_ZSCAN;
                end

                S_ZSCAN: begin
                    r_dv     <= w_issue;
                    r_dv_idx <= r_ptr;
                    if (w_issue) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (r_dv) begin
                        // Held sample is index-1; take the first fall through
                        if ((r_dv_idx >= PAIR_LO) && !r_zfound &&
                            (w_hold_fe >= r_thr) && (w_qa_fe < r_thr)) begin
                            r_zx     <= r_hold_x;
                            r_zfound <= 1'b1;
                        end
                        r_hold_f <= w_qa_f;
                        r_hold_x <= w_qa_x;
                    end
                    if (w_scan_done) begin
                        r_wdiff <= r_work_a - r_work_r;
                        r_state <= S_UMUL;
                    end
                end

                S_UMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_LMUL;
                end

                S_LMUL: begin
                    r_tu    <= r_prod;
                    r_prod  <= w_prod;
                    r_state <= S_FTHR;
                end

                S_FTHR: begin
                    r_tl     <= r_prod;
                    r_ptr    <= SCAN_LO;
                    r_lim    <= r_cnt_ret;
                    r_dv     <= 1'b0;
                    r_iup    <= '0;
                    r_ilo    <= r_adh_i;
                    r_ufound <= 1'b0;
                    r_lfound <= 1'b0;
                    r_state  <= S_FSCAN;
                end

                S_FSCAN: begin
                    r_dv     <= w_issue;
                    r_dv_idx <= r_ptr;
                    if (w_issue) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (r_dv) begin
                        if ((r_dv_idx >= PAIR_LO) && !r_ufound &&
                            (r_dprev >= r_tu) && (w_dcur < r_tu)) begin
                            r_iup    <= AW'(r_dv_idx - 1'b1);
                            r_ufound <= 1'b1;
                        end
                        if ((r_dv_idx >= PAIR_LO) && !r_lfound &&
                            (r_dprev >= r_tl) && (w_dcur < r_tl)) begin
                            r_ilo    <= AW'(r_dv_idx - 1'b1);
                            r_lfound <= 1'b1;
                        end
                        r_dprev <= w_dcur;
                    end
                    if (w_scan_done) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // Hold until the previous result has left
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_o_adh_f   <= {r_adh_f[SW-1], r_adh_f} - {r_base[SW-1], r_base};
                        r_o_adh_x   <= r_adh_x;
                        r_o_base    <= r_base;
                        r_o_pk_f    <= w_peak_f;
                        r_o_pk_x    <= w_peak_x;
                        r_o_zx      <= r_zx;
                        r_o_deform  <= {r_zx[SW-1], r_zx} - {r_apk_x[SW-1], r_apk_x};
                        r_o_work    <= w_wd[WORK_W-1:1];
                        r_o_istart  <= r_iup;
                        r_o_iend    <= r_ilo;
                        r_o_win_ok  <= (w_gap > (AW+2)'(FIT_MIN_GAP));
                        r_o_bempty  <= (r_bcnt == '0);
                        // Clear curve state for the next pair
                        r_cnt_app   <= '0;
                        r_cnt_ret   <= '0;
                        r_apk_f     <= SMIN;
                        r_apk_x     <= '0;
                        r_rpk_f     <= SMIN;
                        r_rpk_x     <= '0;
                        r_adh_f     <= SMAX;
                        r_adh_x     <= '0;
                        r_adh_i     <= '0;
                        r_xmax      <= SMIN;
                        r_xmin      <= SMAX;
                        r_pa_x      <= '0;
                        r_pa_f      <= '0;
                        r_pr_x      <= '0;
                        r_pr_f      <= '0;
                        r_work_a    <= '0;
                        r_work_r    <= '0;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign o_res.valid           = r_out_valid;
    assign o_res.adhesion_force  = r_o_adh_f;
    assign o_res.adhesion_x      = r_o_adh_x;
    assign o_res.baseline_force  = r_o_base;
    assign o_res.peak_force      = r_o_pk_f;
    assign o_res.peak_x          = r_o_pk_x;
    assign o_res.zero_x          = r_o_zx;
    assign o_res.deformation     = r_o_deform;
    assign o_res.dissipated_work = r_o_work;
    assign o_res.fit_start_index = r_o_istart;
    assign o_res.fit_end_index   = r_o_iend;
    assign o_res.fit_window_ok   = r_o_win_ok;
    assign o_res.baseline_empty  = r_o_bempty;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `FCFE_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, (r_cnt_app <= MAXN) && (r_cnt_ret <= MAXN))
    `FCFE_ASSERT_NEXT(a_result_clears, i_clk, i_rst_n, (r_state == S_DONE) && !r_out_valid, r_out_valid && (r_cnt_ret == '0) && (r_state == S_IDLE))
    `FCFE_ASSERT_ALWAYS(a_div_live, i_clk, i_rst_n, (r_state != S_DIV) || ((r_dcnt != '0) && (r_bcnt != '0)))
    `FCFE_ASSERT_NEXT(a_sample_steps, i_clk, i_rst_n, w_smp_acc, r_state == S_MUL)
    `FCFE_ASSERT_ALWAYS(a_fit_start_lo, i_clk, i_rst_n, (r_state != S_DONE) || !r_ufound || (r_iup >= AW'(2)))

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for force_curve_feature_extractor: drives sample and
// register words, predicts each curve-pair result and checks it field by field.
// Depends on fcfe_pkg, the channel interfaces in fcfe_ifs.sv and the RTL top.
`default_nettype none

module testbench;
    import fcfe_pkg::*;

    localparam int  SW         = 24;
    localparam int  DEPTH      = 4096;
    localparam int  SCALE      = 65536;
    localparam bit  KIND_APP   = 1'b0;
    localparam bit  KIND_RET   = 1'b1;
    localparam int  RAND_WORDS = 650;

    // One curve-pair result at the widths of the result channel
    typedef struct {
        logic signed [SW:0]        adh_f;
        logic signed [SW-1:0]      adh_x;
        logic signed [SW-1:0]      base_f;
        logic signed [SW-1:0]      pk_f;
        logic signed [SW-1:0]      pk_x;
        logic signed [SW-1:0]      zero_x;
        logic signed [SW:0]        deform;
        logic signed [DWORK_W-1:0] work;
        logic [11:0]               fit_start;
        logic [11:0]               fit_stop;
        logic                      fit_ok;
        logic                      base_none;
    } curve_result_t;

    // Directed word: lone marks a retract word with nothing loaded before it,
    // whose result simply reports that word back
    typedef struct packed {
        bit             kind;
        logic [SW-1:0]  x;
        logic [SW-1:0]  f;
        bit             last;
        bit             lone;
    } dir_word_t;

    localparam int N_DIR = 22;
    localparam dir_word_t DIR_TAB [N_DIR] = '{
        '{KIND_RET, 24'h800000, 24'h7fffff, 1'b1, 1'b1},
        '{KIND_RET, 24'h7fffff, 24'h800000, 1'b1, 1'b1},
        '{KIND_RET, 24'h000000, 24'h000000, 1'b1, 1'b1},
        // full pair with extreme codes, last on an approach word, and an
        // approach word slipped in among the retract words
        '{KIND_APP, 24'h7fffff, 24'h800000, 1'b0, 1'b0},
        '{KIND_APP, 24'd4000000, 24'd100,   1'b0, 1'b0},
        '{KIND_APP, 24'd0,       24'd200,   1'b1, 1'b0},
        '{KIND_APP, -24'sd4000000, 24'h7fffff, 1'b0, 1'b0},
        '{KIND_APP, 24'h800000, 24'd5000,   1'b0, 1'b0},
        '{KIND_APP, -24'sd8000000, 24'd300, 1'b0, 1'b0},
        '{KIND_RET, -24'sd8000000, 24'd4000, 1'b0, 1'b0},
        '{KIND_RET, -24'sd6000000, -24'sd100, 1'b0, 1'b0},
        '{KIND_APP, -24'sd7000000, 24'd50,  1'b0, 1'b0},
        '{KIND_RET, -24'sd3000000, 24'h800000, 1'b0, 1'b0},
        '{KIND_RET, 24'd0,       -24'sd2000, 1'b0, 1'b0},
        '{KIND_RET, 24'd2000000, 24'd10,    1'b0, 1'b0},
        '{KIND_RET, 24'd4000000, 24'd20,    1'b0, 1'b0},
        '{KIND_RET, 24'd6000000, 24'd30,    1'b0, 1'b0},
        '{KIND_RET, 24'h7fffff, 24'd25,     1'b1, 1'b0},
        // peak ties between the curves: approach wins
        '{KIND_APP, 24'd100,     24'd900,   1'b0, 1'b0},
        '{KIND_APP, 24'd50,      24'd900,   1'b0, 1'b0},
        '{KIND_RET, 24'd50,      24'd900,   1'b0, 1'b0},
        '{KIND_RET, 24'd100,     -24'sd5,   1'b1, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    fcfe_smp_if #(.SW(SW)) smp ();
    fcfe_res_if #(.SW(SW), .IW(12)) res ();
    fcfe_cfg_if #(.DW(17)) cfg ();

    force_curve_feature_extractor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Shadow of the block: stored curves, running trackers and registers
    longint    app_x [DEPTH];
    longint    app_f [DEPTH];
    longint    ret_x [DEPTH];
    longint    ret_f [DEPTH];
    int        n_app, n_ret;
    longint    app_pk_f, app_pk_x, ret_pk_f, ret_pk_x;
    longint    adh_f, adh_x, adh_i;
    longint    x_hi, x_lo;
    bit [63:0] work_app, work_ret;
    longint    base_frac, up_frac, lo_frac;

    curve_result_t pending_results [$];
    int            errors;
    int            rand_words;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void clear_curves();
        n_app    = 0;
        n_ret    = 0;
        app_pk_f = -(64'sd1 <<< (SW - 1));
        app_pk_x = 0;
        ret_pk_f = -(64'sd1 <<< (SW - 1));
        ret_pk_x = 0;
        adh_f    = (64'sd1 <<< (SW - 1)) - 1;
        adh_x    = 0;
        adh_i    = 0;
        x_hi     = -(64'sd1 <<< (SW - 1));
        x_lo     = (64'sd1 <<< (SW - 1)) - 1;
        work_app = '0;
        work_ret = '0;
    endfunction

    function automatic bit [63:0] trapezoid(input longint x0, f0, x1, f1);
        longint dx;
        dx = x1 - x0;
        if (dx < 0)
            dx = -dx;
        return dx * (f0 + f1);
    endfunction

    // Evaluate the loaded pair once the final retract word is in
    function automatic curve_result_t analyze_pair();
        curve_result_t r;
        longint xspan, bsum, bcnt, cs, cc, baseline, zx, app_pkx, pk, pkx;
        longint span, tu, tl, iup, ilo, d0, d1, wd;
        int     i;
        xspan = (n_app > 0) ? x_hi - x_lo : 0;
        bsum  = 0;
        bcnt  = 0;
        for (i = 0; i < n_app; i++) begin
            if ((app_x[i] - x_hi) * SCALE + base_frac * xspan > 0) begin
                bsum += app_f[i];
                bcnt++;
            end
        end
        baseline = (bcnt != 0) ? bsum / bcnt : 0;
        cs = (bcnt != 0) ? bsum : 0;
        cc = (bcnt != 0) ? bcnt : 1;
        zx = (n_app > 0) ? app_x[n_app-1] : 0;
        for (i = n_app - 2; i >= 2; i--) begin
            if (app_f[i] * cc >= cs && app_f[i+1] * cc < cs)
                zx = app_x[i];
        end
        app_pkx = (n_app > 0) ? app_pk_x : 0;
        if (n_app > 0 && !(ret_pk_f > app_pk_f)) begin
            pk  = app_pk_f;
            pkx = app_pk_x;
        end else begin
            pk  = ret_pk_f;
            pkx = ret_pk_x;
        end
        span = pk - adh_f;
        tu   = up_frac * span;
        tl   = lo_frac * span;
        iup  = 0;
        ilo  = adh_i;
        for (i = n_ret - 2; i >= 2; i--) begin
            d0 = (ret_f[i] - adh_f) * SCALE;
            d1 = (ret_f[i+1] - adh_f) * SCALE;
            if (d0 >= tu && d1 < tu)
                iup = i;
            if (d0 >= tl && d1 < tl)
                ilo = i;
        end
        // halve the work difference, truncating toward zero
        wd = longint'(work_app - work_ret);
        wd = wd / 2;
        r.adh_f     = adh_f - baseline;
        r.adh_x     = adh_x;
        r.base_f    = baseline;
        r.pk_f      = pk;
        r.pk_x      = pkx;
        r.zero_x    = zx;
        r.deform    = zx - app_pkx;
        r.work      = wd;
        r.fit_start = iup;
        r.fit_stop  = ilo;
        r.fit_ok    = (ilo - iup > FIT_MIN_GAP);
        r.base_none = (bcnt == 0);
        return r;
    endfunction

    // Advance the shadow by one accepted sample word; 1 when a result is due
    function automatic bit load_sample(input bit kind, input longint x, f, input bit last,
                                       output curve_result_t r);
        if (kind == KIND_APP) begin
            if (n_app < DEPTH) begin
                if (n_app > 0)
                    work_app += trapezoid(app_x[n_app-1], app_f[n_app-1], x, f);
                if (n_app == 0 || f > app_pk_f) begin
                    app_pk_f = f;
                    app_pk_x = x;
                end
                if (x > x_hi)
                    x_hi = x;
                if (x < x_lo)
                    x_lo = x;
                app_x[n_app] = x;
                app_f[n_app] = f;
                n_app++;
            end
            return 1'b0;
        end
        if (n_ret < DEPTH) begin
            if (n_ret > 0)
                work_ret += trapezoid(ret_x[n_ret-1], ret_f[n_ret-1], x, f);
            if (n_ret == 0 || f < adh_f) begin
                adh_f = f;
                adh_x = x;
                adh_i = n_ret;
            end
            if (n_ret == 0 || f > ret_pk_f) begin
                ret_pk_f = f;
                ret_pk_x = x;
            end
            ret_x[n_ret] = x;
            ret_f[n_ret] = f;
            n_ret++;
        end
        if (!last)
            return 1'b0;
        r = analyze_pair();
        clear_curves();
        return 1'b1;
    endfunction

    // Drive one sample word, hold it until taken, then log what it predicts.
    // Valid stays high into the next word unless a gap is drawn.
    task automatic send_word(input bit kind, input logic signed [SW-1:0] x, f,
                             input bit last, input bit burst, input bit lone);
        curve_result_t r;
        int            gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid    <= 1'b1;
        smp.req_type <= kind;
        smp.position <= x;
        smp.force_req <= f;
        smp.last     <= last;
        do @(posedge i_clk); while (!smp.ready);
        if (load_sample(kind, longint'(x), longint'(f), last, r)) begin
            if (lone)
                r = '{adh_f: f, adh_x: x, base_f: 0, pk_f: f, pk_x: x, zero_x: 0,
                      deform: 0, work: 0, fit_start: 0, fit_stop: 0, fit_ok: 0,
                      base_none: 1};
            pending_results.push_back(r);
        end
    endtask

    // Drop valid after a burst of words, then wait for a clock edge
    task automatic release_sample_port();
        smp.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every outstanding result, then let the block settle
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    // Write all three fraction registers back to back while idle
    task automatic write_fractions(input logic [16:0] b, u, l);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [16:0]          val [3];
        int                   k;
        idx = '{CFG_BASELINE, CFG_UPPER, CFG_LOWER};
        val = '{b, u, l};
        drain_results();
        for (k = 0; k < 3; k++) begin
            cfg.valid <= 1'b1;
            cfg.addr  <= idx[k];
            cfg.data  <= val[k];
            do @(posedge i_clk); while (!cfg.ready);
        end
        cfg.valid <= 1'b0;
        base_frac = longint'(b[15:0]);
        up_frac   = longint'(u[16:0]);
        lo_frac   = longint'(l[14:0]);
        @(posedge i_clk);
    endtask

    // Send one approach/retract pair. Shaped curves have a flat baseline,
    // a contact ramp and a retract dip so the crossing searches find real
    // edges; noise curves use raw codes to toggle every bit.
    task automatic send_pair(input int na, nr, input bit shaped, input bit burst);
        logic signed [SW-1:0] x, f;
        int x0, stride, base, amp, slope, depth, c1, c2, c3, i;
        x0     = $urandom_range(0, 1 << 21) - (1 << 20);
        stride = $urandom_range(1, 4000);
        base   = $urandom_range(0, 20000) - 10000;
        amp    = $urandom_range(0, 300);
        slope  = $urandom_range(1, 60000);
        depth  = $urandom_range(0, 500000);
        c1     = $urandom_range(0, na);
        c2     = $urandom_range(0, nr);
        c3     = $urandom_range(c2, nr);
        for (i = 0; i < na; i++) begin
            if (shaped) begin
                x = x0 - i * stride;
                f = base + $urandom_range(0, 2 * amp) - amp + ((i > c1) ? slope * (i - c1) : 0);
            end else begin
                x = $urandom;
                f = $urandom;
            end
            // last on an approach word is noise: it must not end anything
            send_word(KIND_APP, x, f, ($urandom_range(0, 7) == 0), burst, 1'b0);
        end
        for (i = 0; i < nr; i++) begin
            if (shaped) begin
                x = x0 - (nr - 1 - i) * stride;
                f = base + $urandom_range(0, 2 * amp) - amp
                    + ((i < c2) ? slope * (c2 - i) : 0) - ((i >= c2 && i < c3) ? depth : 0);
            end else begin
                x = $urandom;
                f = $urandom;
            end
            if ($urandom_range(0, 31) == 0)
                send_word(KIND_APP, $urandom, $urandom, 1'b0, burst, 1'b0);
            send_word(KIND_RET, x, f, (i == nr - 1), burst, 1'b0);
        end
        release_sample_port();
        rand_words += na + nr;
    endtask

    // Result side: stall at random, take each word and compare it with the
    // oldest prediction
    initial begin
        curve_result_t want;
        int            stall;
        res.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
            if (pending_results.size() == 0) begin
                report("result word with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (res.adhesion_force !== want.adh_f)
                    report($sformatf("adhesion_force %0d want %0d", res.adhesion_force, want.adh_f));
                if (res.adhesion_x !== want.adh_x)
                    report($sformatf("adhesion_x %0d want %0d", res.adhesion_x, want.adh_x));
                if (res.baseline_force !== want.base_f)
                    report($sformatf("baseline_force %0d want %0d", res.baseline_force, want.base_f));
                if (res.peak_force !== want.pk_f)
                    report($sformatf("peak_force %0d want %0d", res.peak_force, want.pk_f));
                if (res.peak_x !== want.pk_x)
                    report($sformatf("peak_x %0d want %0d", res.peak_x, want.pk_x));
                if (res.zero_x !== want.zero_x)
                    report($sformatf("zero_x %0d want %0d", res.zero_x, want.zero_x));
                if (res.deformation !== want.deform)
                    report($sformatf("deformation %0d want %0d", res.deformation, want.deform));
                if (res.dissipated_work !== want.work)
                    report($sformatf("dissipated_work %0d want %0d", res.dissipated_work, want.work));
                if (res.fit_start_index !== want.fit_start)
                    report($sformatf("fit_start_index %0d want %0d", res.fit_start_index,
                                     want.fit_start));
                if (res.fit_end_index !== want.fit_stop)
                    report($sformatf("fit_end_index %0d want %0d", res.fit_end_index,
                                     want.fit_stop));
                if (res.fit_window_ok !== want.fit_ok)
                    report($sformatf("fit_window_ok %0b want %0b", res.fit_window_ok, want.fit_ok));
                if (res.baseline_empty !== want.base_none)
                    report($sformatf("baseline_empty %0b want %0b", res.baseline_empty,
                                     want.base_none));
            end
        end
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #12_000_000;
        $display("force_curve_feature_extractor test failed");
        $finish;
    end

    // Stimulus: reset, directed table, empty-baseline and capacity pairs, register sweep with random pairs
    initial begin
        int k, waited, phase;
        errors     = 0;
        rand_words = 0;
        base_frac  = 13107;
        up_frac    = 52429;
        lo_frac    = 13107;
        clear_curves();
        i_rst_n       <= 1'b0;
        smp.valid     <= 1'b0;
        smp.req_type  <= KIND_APP;
        smp.position  <= '0;
        smp.force_req <= '0;
        smp.last      <= 1'b0;
        cfg.valid     <= 1'b0;
        cfg.addr      <= CFG_BASELINE;
        cfg.data      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table under reset register values
        for (k = 0; k < N_DIR; k++)
            send_word(DIR_TAB[k].kind, DIR_TAB[k].x, DIR_TAB[k].f, DIR_TAB[k].last,
                      1'b0, DIR_TAB[k].lone);
        release_sample_port();

        // empty baseline set: a zero share selects no approach word
        write_fractions(17'd0, 17'd39322, 17'd0);
        send_pair(12, 10, 1'b1, 1'b0);
        send_pair(0, 6, 1'b1, 1'b0);

        // both curves past capacity, final retract word dropped
        write_fractions(17'd13107, 17'd52429, 17'd13107);
        send_pair(DEPTH + 4, DEPTH + 4, 1'b0, 1'b1);
        rand_words = 0;

        phase = 0;
        while (rand_words < RAND_WORDS) begin
            if (phase % 3 == 0) begin
                case ((phase / 3) % 4)
                    0: write_fractions(17'd0, 17'd39322, 17'd0);
                    1: write_fractions(17'd32768, 17'd65536, 17'd26214);
                    2: write_fractions(17'h1ffff, 17'h1ffff, 17'h1ffff);
                    default: write_fractions($urandom_range(0, 32768),
                                             $urandom_range(39322, 65536),
                                             $urandom_range(0, 26214));
                endcase
            end
            send_pair(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40),
                      $urandom_range(1, 40), ($urandom_range(0, 4) != 0),
                      ($urandom_range(0, 3) == 0));
            phase++;
        end

        waited = 0;
        while (pending_results.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (64) @(posedge i_clk);
        if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
        if (errors == 0)
            $display("force_curve_feature_extractor test passed");
        else
            $display("force_curve_feature_extractor test failed");
        $finish;
    end

endmodule

`default_nettype wire
